[rtl/core/rrn_pkg.sv]
// ----------------------------------------------------------------------------
// rrn_pkg
// Shared types and constants of the regression RAM node.
// ----------------------------------------------------------------------------
package rrn_pkg;

  localparam int MAP_WIDTH   = 48;
  localparam int POS_BITS    = 6;
  localparam int CFG_WIDTH   = 48;
  localparam int CFG_IDX_W   = 2;
  localparam int COUNT_W     = 16;
  localparam int ACC_W       = 48;
  localparam int VALUE_W     = 32;
  localparam int FUNC_W      = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TRAIN = 2'd0,
    FUNC_VOTE  = 2'd1,
    FUNC_FIT   = 2'd2,
    FUNC_APPLY = 2'd3
  } func_t;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_ZERO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ONE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TUPLE_MAP = 2'd2;

  localparam logic signed [ACC_W-1:0] MAX48 = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] MIN48 = {1'b1, {(ACC_W-1){1'b0}}};

  // Saturating 48-bit add; both operands already sign extended to 48 bits.
  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? MIN48 : MAX48;
    end
    return s[ACC_W-1:0];
  endfunction

  // Divider start and result.
  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] dividend;
    logic [COUNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/core/rrn_if.sv]
// ----------------------------------------------------------------------------
// rrn_in_if / rrn_out_if
// Valid/ready channels of the regression RAM node.
// ----------------------------------------------------------------------------
interface rrn_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] image;
  logic signed [31:0] value;
  modport source (output valid, func, image, value, input ready);
  modport sink   (input valid, func, image, value, output ready);
endinterface

interface rrn_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] vote_count;
  logic signed [47:0] vote_sum;
  modport source (output valid, vote_count, vote_sum, input ready);
  modport sink   (input valid, vote_count, vote_sum, output ready);
endinterface

[rtl/core/rrn_div.sv]
// ----------------------------------------------------------------------------
// rrn_div
// Signed 48-bit by unsigned 16-bit restoring divider, one quotient bit per
// cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module rrn_div
  import rrn_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEP_W = $clog2(ACC_W + 1);

  logic [ACC_W-1:0]   quo;
  logic [COUNT_W:0]   rem;
  logic [COUNT_W-1:0] dvs;
  logic               neg;
  logic               busy;
  logic               done;
  logic [STEP_W-1:0]  steps;
  logic [COUNT_W+1:0] trial;

  assign trial = {rem, quo[ACC_W-1]} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(ACC_W);
        neg   <= req.dividend[ACC_W-1];
        quo   <= req.dividend[ACC_W-1] ? (~req.dividend + 1'b1) : req.dividend;
        rem   <= '0;
        dvs   <= req.divisor;
      end else if (busy) begin
        if (trial[COUNT_W+1]) begin
          rem <= trial[COUNT_W:0] + {1'b0, dvs};
          quo <= {quo[ACC_W-2:0], 1'b0};
        end else begin
          rem <= trial[COUNT_W:0];
          quo <= {quo[ACC_W-2:0], 1'b1};
        end
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The restore above uses a one-bit-wider remainder so every step is exact.
  assign rsp = {done, (neg ? (~quo + 1'b1) : quo)};

endmodule

[rtl/core/regression_ram_node_core.sv]
// ----------------------------------------------------------------------------
// regression_ram_node_core
// Weightless regression RAM node with a table held in one synchronous memory.
// ----------------------------------------------------------------------------
// Train, vote and add-fit transactions read the addressed entry from the
// table memory on acceptance and, in state S_RMW, write it back (or load the
// vote result into the output register). An apply-fit transaction walks all
// 2**TUPLE_BITS entries; each valid entry with a nonzero count goes through
// the serial divider. After reset a clearing pass writes every entry
// invalid, one per cycle, during which no transaction is accepted.
module regression_ram_node_core
  import rrn_pkg::*;
#(
  parameter int TUPLE_BITS = 8,
  parameter int IMAGE_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data,
  rrn_in_if.sink               in_ch,
  rrn_out_if.source            out_ch
);

  localparam int DEPTH  = 1 << TUPLE_BITS;
  localparam int ONES_W = $clog2(TUPLE_BITS + 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RMW   = 7'b0000100,
    S_AREAD = 7'b0001000,
    S_ACHK  = 7'b0010000,
    S_ADIV  = 7'b0100000,
    S_AWB   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] count;
    logic [ACC_W-1:0]   sum;
    logic [ACC_W-1:0]   fit;
  } entry_t;

  // Configuration registers.
  logic [3:0]           min_zero;
  logic [3:0]           min_one;
  logic [MAP_WIDTH-1:0] tuple_map;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_zero  <= '0;
      min_one   <= '0;
      tuple_map <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_ZERO:  min_zero  <= cfg_data[3:0];
        REG_MIN_ONE:   min_one   <= cfg_data[3:0];
        REG_TUPLE_MAP: tuple_map <= cfg_data[MAP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Address gather: each address bit picks one image bit through the map.
  logic [TUPLE_BITS-1:0] gaddr;
  logic [ONES_W-1:0]     gones;
  logic                  grej;

  always_comb begin
    logic [POS_BITS-1:0] pos;
    gones = '0;
    for (int i = 0; i < TUPLE_BITS; i++) begin
      pos = '0;
      if (i * POS_BITS + POS_BITS <= MAP_WIDTH) begin
        pos = tuple_map[i*POS_BITS +: POS_BITS];
      end
      gaddr[i] = (32'(pos) < IMAGE_BITS) ? in_ch.image[pos] : 1'b0;
      gones = gones + ONES_W'(gaddr[i]);
    end
    grej = (32'(gones) < 32'(min_one)) ||
           (32'(TUPLE_BITS) - 32'(gones) < 32'(min_zero));
  end

  // Table memory, one read and one write port.
  entry_t mem [DEPTH];
  entry_t rd;
  logic                  mem_re, mem_we;
  logic [TUPLE_BITS-1:0] rd_addr, wr_addr;
  entry_t                wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (mem_re) rd <= mem[rd_addr];
  end

  state_t                state;
  logic [TUPLE_BITS-1:0] addr;
  logic [TUPLE_BITS:0]   walk;
  func_t                 op;
  logic                  rej;
  logic [ACC_W-1:0]      val;
  entry_t                ent;
  div_req_t              dreq;
  div_rsp_t              drsp;

  logic out_free;
  assign out_free = !out_ch.valid || out_ch.ready;

  // A vote may only start when the output register can take its result.
  assign in_ch.ready = (state == S_IDLE) &&
                       (func_t'(in_ch.func) != FUNC_VOTE || out_free);

  logic accept;
  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    mem_re  = 1'b0;
    rd_addr = gaddr;
    if (state == S_IDLE && accept && func_t'(in_ch.func) != FUNC_APPLY) begin
      mem_re = 1'b1;
    end else if (state == S_AREAD) begin
      mem_re  = 1'b1;
      rd_addr = walk[TUPLE_BITS-1:0];
    end
  end

  entry_t upd;
  always_comb begin
    upd = rd;
    unique case (op)
      FUNC_TRAIN: begin
        if (!rd.valid) begin
          upd.valid = 1'b1;
          upd.count = COUNT_W'(1);
          upd.sum   = val;
          upd.fit   = '0;
        end else begin
          if (rd.count != '1) upd.count = rd.count + 1'b1;
          upd.sum = sat_add(rd.sum, val);
        end
      end
      FUNC_FIT:  if (rd.valid) upd.fit = sat_add(rd.fit, val);
      default: ;
    endcase
  end

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = addr;
    wr_data = upd;
    unique case (state)
      S_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = walk[TUPLE_BITS-1:0];
        wr_data = '0;
      end
      S_RMW: mem_we = (op == FUNC_TRAIN) || (op == FUNC_FIT);
      S_ACHK: begin
        mem_we  = !(rd.valid && rd.count != '0);
        wr_addr = walk[TUPLE_BITS-1:0];
        wr_data = rd;
        wr_data.fit = '0;
      end
      S_AWB: begin
        mem_we  = 1'b1;
        wr_addr = walk[TUPLE_BITS-1:0];
        wr_data = ent;
      end
      default: ;
    endcase
  end

  assign dreq.start    = (state == S_ACHK) && rd.valid && rd.count != '0;
  assign dreq.dividend = rd.fit;
  assign dreq.divisor  = rd.count;

  rrn_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      walk         <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          walk <= walk + 1'b1;
          if (walk == (TUPLE_BITS+1)'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            op   <= func_t'(in_ch.func);
            addr <= gaddr;
            rej  <= grej;
            val  <= ACC_W'(in_ch.value);
            walk <= '0;
            state <= (func_t'(in_ch.func) == FUNC_APPLY) ? S_AREAD : S_RMW;
          end
        end
        S_RMW: begin
          if (op == FUNC_VOTE) begin
            out_ch.valid      <= 1'b1;
            out_ch.vote_count <= (rej || !rd.valid) ? '0 : rd.count;
            out_ch.vote_sum   <= (rej || !rd.valid) ? '0 : rd.sum;
          end
          state <= S_IDLE;
        end
        S_AREAD: state <= S_ACHK;
        S_ACHK: begin
          ent <= rd;
          if (dreq.start) begin
            state <= S_ADIV;
          end else begin
            walk  <= walk + 1'b1;
            state <= (walk == (TUPLE_BITS+1)'(DEPTH - 1)) ? S_IDLE : S_AREAD;
          end
        end
        S_ADIV: begin
          if (drsp.done) begin
            ent.sum <= sat_add(ent.sum, drsp.quotient);
            ent.fit <= '0;
            state   <= S_AWB;
          end
        end
        S_AWB: begin
          walk  <= walk + 1'b1;
          state <= (walk == (TUPLE_BITS+1)'(DEPTH - 1)) ? S_IDLE : S_AREAD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/rrn_checker.sv]
// ----------------------------------------------------------------------------
// rrn_checker
// Port-level assertions for the regression RAM node, bound to the top level.
// ----------------------------------------------------------------------------
module rrn_checker
  import rrn_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_func,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_count,
  input logic [47:0] out_sum
);

  // A result held in the output register keeps its payload while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_sum))
    else $error("vote result changed while stalled");

  // Transactions are never accepted back to back.
  a_two_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // A vote result appears only after an accepted vote.
  a_vote_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_func == FUNC_VOTE, 2))
    else $error("vote result without vote transaction");

  // The input is not ready when reset falls, at the start of the clearing pass.
  a_clear: assert property (@(posedge clk) $fell(rst) |-> !in_ready)
    else $error("input accepted during clearing pass");

endmodule

bind regression_ram_node_core rrn_checker u_rrn_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_func(in_ch.func),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_count(out_ch.vote_count), .out_sum(out_ch.vote_sum)
);

[verif/regression_ram_node_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// regression_ram_node_core_tb
// Self-checking testbench of the regression RAM node.
// ----------------------------------------------------------------------------
// A queue-fed driver sends train, vote, add-fit and apply-fit transactions.
// A table model mirrors every accepted transaction and predicts each vote
// result. A monitor compares each result with the oldest prediction. The
// mapping and the thresholds are rewritten between phases, while the node
// is idle. Both channels insert random gaps.
// ----------------------------------------------------------------------------
module regression_ram_node_core_tb;
  import rrn_pkg::*;

  localparam int TUPLE_BITS = 8;
  localparam int IMAGE_BITS = 64;
  localparam int DEPTH      = 1 << TUPLE_BITS;
  // An apply walks the whole table, and each valid entry goes through the
  // serial divider. This settle time covers the slowest apply with margin.
  localparam int SETTLE     = 16000;

  typedef struct {
    func_t              func;
    logic [63:0]        image;
    logic signed [31:0] value;
  } node_op_t;

  typedef struct {
    logic [15:0]        count;
    logic signed [47:0] sum;
  } vote_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_WIDTH-1:0] cfg_data;

  rrn_in_if  in_ch ();
  rrn_out_if out_ch ();

  regression_ram_node_core #(
    .TUPLE_BITS(TUPLE_BITS),
    .IMAGE_BITS(IMAGE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #4 clk = ~clk;

  // Mirror of the node's table and registers.
  bit                 tbl_valid [DEPTH];
  logic [15:0]        tbl_count [DEPTH];
  logic signed [47:0] tbl_sum   [DEPTH];
  logic signed [47:0] tbl_fit   [DEPTH];
  logic [3:0]         min_zero_q;
  logic [3:0]         min_one_q;
  logic [47:0]        tuple_map_q;

  node_op_t pending_ops[$];
  vote_t    expected_votes[$];
  bit       quiet;
  int       errors;
  int       votes_seen;
  int       applies_sent;
  int       phases;

  function automatic logic signed [47:0] clamp48(longint v);
    if (v > longint'(MAX48)) return MAX48;
    if (v < longint'(MIN48)) return MIN48;
    return v[47:0];
  endfunction

  // Applies one accepted transaction to the table mirror. A vote pushes the
  // result it must produce.
  task automatic update_table(node_op_t op);
    int   addr;
    int   ones;
    int   pos;
    bit   bitv;
    bit   rejected;
    vote_t v;
    longint q;
    addr = 0;
    ones = 0;
    if (op.func == FUNC_APPLY) begin
      applies_sent++;
      for (int i = 0; i < DEPTH; i++) begin
        if (tbl_valid[i] && tbl_count[i] != 0) begin
          // Signed division truncates toward zero.
          q = longint'(tbl_fit[i]) / longint'({48'd0, tbl_count[i]});
          tbl_sum[i] = clamp48(longint'(tbl_sum[i]) + q);
        end
        tbl_fit[i] = '0;
      end
      return;
    end
    // All eight positions fit in the 48-bit map and every position is
    // inside a 64-bit image, so the address is a plain bit gather.
    for (int i = 0; i < TUPLE_BITS; i++) begin
      pos  = tuple_map_q[6*i +: 6];
      bitv = (pos < IMAGE_BITS) ? op.image[pos] : 1'b0;
      ones += bitv;
      addr |= int'(bitv) << i;
    end
    rejected = (ones < min_one_q) || ((TUPLE_BITS - ones) < min_zero_q);
    case (op.func)
      FUNC_TRAIN: begin
        if (!tbl_valid[addr]) begin
          tbl_valid[addr] = 1'b1;
          tbl_count[addr] = 16'd1;
          tbl_sum[addr]   = 48'(op.value);
          tbl_fit[addr]   = '0;
        end else begin
          if (tbl_count[addr] != 16'hFFFF) tbl_count[addr]++;
          tbl_sum[addr] = clamp48(longint'(tbl_sum[addr]) + longint'(op.value));
        end
      end
      FUNC_FIT: begin
        if (tbl_valid[addr])
          tbl_fit[addr] = clamp48(longint'(tbl_fit[addr]) + longint'(op.value));
      end
      default: begin
        if (rejected || !tbl_valid[addr]) begin
          v.count = '0;
          v.sum   = '0;
        end else begin
          v.count = tbl_count[addr];
          v.sum   = tbl_sum[addr];
        end
        expected_votes.push_back(v);
      end
    endcase
  endtask

  // Driver: one transaction in flight; after each acceptance a random gap is
  // drawn unless the run is in a quiet stretch.
  int       gap_left;
  node_op_t in_flight;
  always @(posedge clk) begin
    int g;
    node_op_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
      gap_left    <= 0;
    end else begin
      g = gap_left;
      if (in_ch.valid && in_ch.ready) begin
        update_table(in_flight);
        g = quiet ? 0 : $urandom_range(0, 9);
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Hold the current transaction.
      end else if (g != 0) begin
        gap_left    <= g - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        nxt          = pending_ops.pop_front();
        in_flight    <= nxt;
        in_ch.func   <= nxt.func;
        in_ch.image  <= nxt.image;
        in_ch.value  <= nxt.value;
        in_ch.valid  <= 1'b1;
        gap_left     <= 0;
      end else begin
        in_ch.valid <= 1'b0;
        gap_left    <= 0;
      end
    end
  end

  // Monitor: checks every vote result and stalls the result channel.
  int stall_left;
  always @(posedge clk) begin
    int s;
    vote_t e;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      s = stall_left;
      if (out_ch.valid && out_ch.ready) begin
        votes_seen++;
        if (expected_votes.size() == 0) begin
          $error("unexpected vote result: count %0d sum %0d",
                 out_ch.vote_count, out_ch.vote_sum);
          errors++;
        end else begin
          e = expected_votes.pop_front();
          if (out_ch.vote_count !== e.count) begin
            $error("vote_count: expected %0d, actual %0d", e.count, out_ch.vote_count);
            errors++;
          end
          if (out_ch.vote_sum !== e.sum) begin
            $error("vote_sum: expected %0d, actual %0d", e.sum, out_ch.vote_sum);
            errors++;
          end
        end
        s = quiet ? 0 : $urandom_range(0, 9);
      end
      if (s != 0) begin
        stall_left   <= s - 1;
        out_ch.ready <= 1'b0;
      end else begin
        stall_left   <= 0;
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_op(func_t f, logic [63:0] img, logic signed [31:0] val);
    node_op_t op;
    op.func  = f;
    op.image = img;
    op.value = val;
    pending_ops.push_back(op);
  endtask

  // Waits until every queued transaction has gone in and every vote result
  // has come out, then lets an apply that may still run finish.
  task automatic drain();
    wait (pending_ops.size() == 0 && !in_ch.valid && gap_left == 0);
    wait (expected_votes.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_MIN_ZERO: min_zero_q  = data[3:0];
      REG_MIN_ONE:  min_one_q   = data[3:0];
      default:      tuple_map_q = data;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(int mz, int mo, logic [47:0] map);
    write_reg(REG_MIN_ZERO, 48'(mz));
    write_reg(REG_MIN_ONE, 48'(mo));
    write_reg(REG_TUPLE_MAP, map);
    phases++;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2, 3: return $signed(32'($urandom_range(0, 2000)) - 32'd1000);
      default: return $signed($urandom);
    endcase
  endfunction

  // Random phase: most images come from a small pool so that trains, votes
  // and fits meet on the same entries; the rest are fresh noise.
  task automatic random_phase(int n);
    logic [63:0] pool[8];
    logic [63:0] img;
    int r;
    func_t f;
    foreach (pool[k]) pool[k] = {$urandom, $urandom};
    for (int k = 0; k < n; k++) begin
      if (k % 90 == 0) quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 999);
      if (r < 400)      f = FUNC_TRAIN;
      else if (r < 730) f = FUNC_VOTE;
      else if (r < 985) f = FUNC_FIT;
      else              f = FUNC_APPLY;
      img = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 7)]
                                         : {$urandom, $urandom};
      push_op(f, img, pick_value());
      // Keep the queue short so gaps and stalls stay interleaved.
      wait (pending_ops.size() < 4);
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.func   = FUNC_TRAIN;
    in_ch.image  = '0;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    quiet        = 1'b0;
    errors       = 0;
    votes_seen   = 0;
    applies_sent = 0;
    phases       = 0;
    min_zero_q   = '0;
    min_one_q    = '0;
    tuple_map_q  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_count[i] = '0;
      tbl_sum[i]   = '0;
      tbl_fit[i]   = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the reset mapping: every address bit reads image
    // bit zero, so only addresses 0x00 and 0xFF are reachable.
    push_op(FUNC_VOTE,  64'h0, 32'sd0);              // vote on a missing entry
    push_op(FUNC_FIT,   64'h0, 32'sd5);              // fit on a missing entry
    push_op(FUNC_TRAIN, 64'h0, 32'sh7FFFFFFF);
    push_op(FUNC_TRAIN, 64'hFFFFFFFFFFFFFFFF, 32'sh80000000);
    push_op(FUNC_TRAIN, 64'h0, 32'sd3);
    push_op(FUNC_VOTE,  64'h0, 32'sd0);
    push_op(FUNC_VOTE,  64'hFFFFFFFFFFFFFFFF, 32'sd0);
    push_op(FUNC_FIT,   64'h0, 32'sh80000000);
    push_op(FUNC_FIT,   64'hFFFFFFFFFFFFFFFF, 32'sd7);
    push_op(FUNC_APPLY, 64'h0, 32'sd0);
    push_op(FUNC_VOTE,  64'h0, 32'sd0);
    push_op(FUNC_VOTE,  64'hFFFFFFFFFFFFFFFF, 32'sd0);
    drain();

    // Thresholds at their extremes reject every tuple.
    set_config(8, 8, 48'hFFFFFFFFFFFF);
    push_op(FUNC_TRAIN, 64'h8000000000000000, 32'sd9);
    push_op(FUNC_VOTE,  64'h8000000000000000, 32'sd0);
    push_op(FUNC_VOTE,  64'h0, 32'sd0);
    drain();

    // A spread mapping over the top and bottom bits with mid thresholds.
    set_config(4, 4, {6'd63, 6'd62, 6'd33, 6'd32, 6'd31, 6'd2, 6'd1, 6'd0});
    push_op(FUNC_TRAIN, 64'hC000000380000001, 32'sd100);
    push_op(FUNC_TRAIN, 64'hC000000380000001, -32'sd1);
    push_op(FUNC_FIT,   64'hC000000380000001, -32'sd7);
    push_op(FUNC_APPLY, 64'h0, 32'sd0);
    push_op(FUNC_VOTE,  64'hC000000380000001, 32'sd0);
    push_op(FUNC_TRAIN, 64'h0000000000000007, 32'sd1);
    push_op(FUNC_VOTE,  64'h0000000000000007, 32'sd0);
    drain();

    // Back-to-back burst on entry zero with extreme values, no gaps.
    set_config(0, 0, 48'h0);
    quiet = 1'b1;
    for (int k = 0; k < 24; k++) begin
      push_op(FUNC_TRAIN, 64'h0, 32'sh7FFFFFFF);
      if (pending_ops.size() > 64) wait (pending_ops.size() < 32);
    end
    push_op(FUNC_VOTE, 64'h0, 32'sd0);
    for (int k = 0; k < 24; k++) begin
      push_op(FUNC_FIT, 64'h0, 32'sh80000000);
      if (pending_ops.size() > 64) wait (pending_ops.size() < 32);
    end
    push_op(FUNC_APPLY, 64'h0, 32'sd0);
    push_op(FUNC_VOTE,  64'h0, 32'sd0);
    quiet = 1'b0;
    drain();

    // Random phases, each under a fresh configuration.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: set_config(0, 0, {$urandom, $urandom});
        1: set_config($urandom_range(0, 4), $urandom_range(0, 4), {$urandom, $urandom});
        2: set_config(0, 8, {$urandom, $urandom});
        3: set_config(8, 0, {$urandom, $urandom});
        default: set_config($urandom_range(0, 8), $urandom_range(0, 8),
                            {$urandom, $urandom});
      endcase
      random_phase(270);
      drain();
    end

    $display("Checked %0d vote results over %0d register settings, %0d table applies.",
             votes_seen, phases, applies_sent);
    $display("Covered missing entries, rejection, extreme values and back-to-back bursts.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #24000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
rtl/core/rrn_pkg.sv
rtl/core/rrn_if.sv
rtl/core/rrn_div.sv
rtl/core/regression_ram_node_core.sv
rtl/core/rrn_checker.sv
verif/regression_ram_node_core_tb.sv
